FILE: rtl/float_precision_trimmer_macros.svh
// Assertion macros for the precision trimmer RTL
`ifndef FLOAT_PRECISION_TRIMMER_MACROS_SVH
`define FLOAT_PRECISION_TRIMMER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define FPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpt check failed");

// Next-cycle implication, checked out of reset
`define FPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpt check failed");

`endif

FILE: rtl/fpt_pkg.sv
// Types and constants of the precision trimmer pipeline
package fpt_pkg;

    localparam int EXP_BIAS = 127;
    localparam int U_W      = 39;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_ROUNDING  = 3'd1;
    localparam logic [2:0] REG_IN_BW     = 3'd2;
    localparam logic [2:0] REG_IN_FL     = 3'd3;
    localparam logic [2:0] REG_OUT_BW    = 3'd4;
    localparam logic [2:0] REG_OUT_FL    = 3'd5;
    localparam logic [2:0] REG_MANT_BITS = 3'd6;
    localparam logic [2:0] REG_EXP_BITS  = 3'd7;

    typedef struct packed {
        logic              mode;
        logic              stoch;
        logic [4:0]        in_bw;
        logic signed [6:0] in_fl;
        logic [4:0]        out_bw;
        logic signed [6:0] out_fl;
        logic [4:0]        mbits;
        logic [3:0]        ebits;
    } cfg_t;

    typedef struct packed {
        logic [31:0]    value;
        logic [U_W-1:0] u39;
        logic           use_out;
        logic           last;
    } in_t;

    typedef struct packed {
        logic [31:0]       x;
        logic              sign;
        logic              nan;
        logic              mini;
        logic              stoch;
        logic              last;
        logic [23:0]       m;
        logic signed [8:0] k;
        logic [23:0]       lim;
        logic signed [6:0] fl;
        logic [U_W-1:0]    u39;
        logic [7:0]        ef;
        logic [22:0]       fr;
        logic [4:0]        sh;
        logic              mzero;
        logic              msat;
        logic [7:0]        sat_fe;
    } s1_t;

    typedef struct packed {
        logic [31:0]       x;
        logic              sign;
        logic              nan;
        logic              mini;
        logic              stoch;
        logic              last;
        logic [23:0]       ip;
        logic [U_W-1:0]    f39;
        logic              sticky;
        logic              over;
        logic [23:0]       lim;
        logic signed [6:0] fl;
        logic [U_W-1:0]    u39;
        logic [7:0]        ef;
        logic [22:0]       fr;
        logic [4:0]        sh;
        logic              mzero;
        logic              msat;
        logic [7:0]        sat_fe;
        logic              minc;
    } s2_t;

    typedef struct packed {
        logic [31:0]       x;
        logic              sign;
        logic              nan;
        logic              mini;
        logic              stoch;
        logic              last;
        logic [23:0]       n;
        logic signed [6:0] fl;
        logic [31:0]       mini_word;
    } s3_t;

endpackage

FILE: rtl/fpt_decode.sv
// Stage 1: unpack the word and resolve the selected format
module fpt_decode
    import fpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  cfg_t cfg,
    input  logic in_valid,
    input  in_t  in_data,
    output logic out_valid,
    output s1_t  out_data
);

    logic              valid_reg;
    s1_t               data_reg;
    s1_t               data_next;
    logic [4:0]        bw_raw;
    logic [4:0]        bw;
    logic signed [6:0] fl_raw;
    logic signed [6:0] fl;
    logic [23:0]       hi24;
    logic signed [8:0] e;
    logic [4:0]        bm;
    logic [3:0]        be;
    logic [8:0]        half;
    logic [8:0]        lo_thr;
    logic [8:0]        hi_thr;

    always_comb
    begin
        bw_raw = in_data.use_out ? cfg.out_bw : cfg.in_bw;
        fl_raw = in_data.use_out ? cfg.out_fl : cfg.in_fl;
        bw = (bw_raw < 5'd2) ? 5'd2 : ((bw_raw > 5'd24) ? 5'd24 : bw_raw);
        fl = (fl_raw < -7'sd32) ? -7'sd32 : ((fl_raw > 7'sd32) ? 7'sd32 : fl_raw);
        hi24 = (24'd1 << (bw - 5'd1)) - 24'd1;

        data_next.x     = in_data.value;
        data_next.sign  = in_data.value[31];
        data_next.ef    = in_data.value[30:23];
        data_next.fr    = in_data.value[22:0];
        data_next.mini  = cfg.mode;
        data_next.stoch = cfg.stoch;
        data_next.last  = in_data.last;
        data_next.u39   = in_data.u39;
        data_next.nan   = !cfg.mode && (data_next.ef == 8'hFF) && (data_next.fr != 23'd0);
        data_next.lim   = hi24 + {23'd0, data_next.sign};
        data_next.fl    = fl;

        if (data_next.ef == 8'd0)
        begin
            data_next.m = {1'b0, data_next.fr};
            e = -9'sd149;
        end
        else
        begin
            data_next.m = {1'b1, data_next.fr};
            e = $signed({1'b0, data_next.ef}) - 9'sd150;
        end
        data_next.k = e + 9'(fl);

        // minifloat exponent window
        bm = (cfg.mbits > 5'd23) ? 5'd23 : cfg.mbits;
        be = (cfg.ebits < 4'd2) ? 4'd2 : ((cfg.ebits > 4'd8) ? 4'd8 : cfg.ebits);
        half   = 9'd1 << (be - 4'd1);
        lo_thr = 9'd128 - half;
        hi_thr = 9'd127 + half;
        data_next.sh     = 5'd23 - bm;
        data_next.mzero  = (data_next.ef == 8'd0) || ({1'b0, data_next.ef} < lo_thr);
        data_next.msat   = {1'b0, data_next.ef} > hi_thr;
        data_next.sat_fe = hi_thr[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/fpt_shift.sv
// Stage 2: align the significand to the fixed-point grid, pick the minifloat increment
module fpt_shift
    import fpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  s1_t  in_data,
    output logic out_valid,
    output s2_t  out_data
);

    logic           valid_reg;
    s2_t            data_reg;
    s2_t            data_next;
    logic [47:0]    shl;
    logic [8:0]     nk;
    logic [6:0]     shr;
    logic [87:0]    wide;
    logic [22:0]    lowmask;
    logic [U_W-1:0] low39;
    logic [U_W:0]   msum;
    logic           inc_near;

    always_comb
    begin
        data_next.x      = in_data.x;
        data_next.sign   = in_data.sign;
        data_next.nan    = in_data.nan;
        data_next.mini   = in_data.mini;
        data_next.stoch  = in_data.stoch;
        data_next.last   = in_data.last;
        data_next.lim    = in_data.lim;
        data_next.fl     = in_data.fl;
        data_next.u39    = in_data.u39;
        data_next.ef     = in_data.ef;
        data_next.fr     = in_data.fr;
        data_next.sh     = in_data.sh;
        data_next.mzero  = in_data.mzero;
        data_next.msat   = in_data.msat;
        data_next.sat_fe = in_data.sat_fe;

        shl  = '0;
        nk   = '0;
        shr  = '0;
        wide = '0;
        if (in_data.k >= 9'sd0)
        begin
            if (in_data.k <= 9'sd24)
            begin
                shl = 48'(in_data.m) << in_data.k[4:0];
            end
            data_next.ip     = shl[23:0];
            data_next.f39    = '0;
            data_next.sticky = 1'b0;
            data_next.over   = ((in_data.k > 9'sd24) && (in_data.m != 24'd0)) ||
                               (shl > 48'(in_data.lim));
        end
        else
        begin
            // everything past 64 places lands in the sticky bits
            nk   = -in_data.k;
            shr  = (nk > 9'd64) ? 7'd64 : nk[6:0];
            wide = {in_data.m, 64'd0} >> shr;
            data_next.ip     = wide[87:64];
            data_next.f39    = wide[63:25];
            data_next.sticky = |wide[24:0];
            data_next.over   = (wide[87:64] > in_data.lim) ||
                               ((wide[87:64] == in_data.lim) && (|wide[63:0]));
        end

        lowmask  = 23'(23'd1 << in_data.sh) - 23'd1;
        low39    = U_W'(in_data.fr & lowmask) << (6'd39 - 6'(in_data.sh));
        msum     = {1'b0, low39} + {1'b0, in_data.u39};
        inc_near = (in_data.sh != 5'd0) && in_data.fr[5'(in_data.sh - 5'd1)];
        data_next.minc = in_data.stoch ? msum[U_W] : inc_near;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/fpt_round.sv
// Stage 3: round the fixed-point integer, finish the minifloat word
module fpt_round
    import fpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  s2_t  in_data,
    output logic out_valid,
    output s3_t  out_data
);

    logic         valid_reg;
    s3_t          data_reg;
    s3_t          data_next;
    logic         inc;
    logic [U_W:0] fsum;
    logic [22:0]  lowmask;
    logic [23:0]  msum;
    logic [22:0]  mant;
    logic [8:0]   fe;

    always_comb
    begin
        data_next.x     = in_data.x;
        data_next.sign  = in_data.sign;
        data_next.nan   = in_data.nan;
        data_next.mini  = in_data.mini;
        data_next.stoch = in_data.stoch;
        data_next.last  = in_data.last;
        data_next.fl    = in_data.fl;

        fsum = {1'b0, in_data.f39} + {1'b0, in_data.u39};
        if (!in_data.stoch)
        begin
            inc = in_data.f39[U_W-1];
        end
        else if (!in_data.sign)
        begin
            inc = fsum[U_W];
        end
        else
        begin
            inc = !((in_data.u39 > in_data.f39) ||
                    ((in_data.u39 == in_data.f39) && !in_data.sticky));
        end
        data_next.n = in_data.over ? in_data.lim : (in_data.ip + {23'd0, inc});

        // minifloat: a mantissa carry bumps the exponent
        lowmask = 23'(23'd1 << in_data.sh) - 23'd1;
        msum    = {1'b0, in_data.fr & ~lowmask} + (24'(in_data.minc) << in_data.sh);
        if (in_data.msat)
        begin
            mant = ~lowmask;
            fe   = {1'b0, in_data.sat_fe};
        end
        else
        begin
            mant = msum[22:0];
            fe   = {1'b0, in_data.ef} + {8'd0, msum[23]};
        end

        if (in_data.mzero)
        begin
            data_next.mini_word = '0;
        end
        else if (fe >= 9'd255)
        begin
            data_next.mini_word = {in_data.sign, 8'hFF, 23'd0};
        end
        else
        begin
            data_next.mini_word = {in_data.sign, fe[7:0], mant};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/fpt_pack.sv
// Stage 4: normalize the fixed-point integer back to a single-precision word, or pass the minifloat or NaN word through
module fpt_pack
    import fpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  s3_t         in_data,
    output logic        out_valid,
    output logic [31:0] word,
    output logic        last
);

    logic              valid_reg;
    logic [31:0]       word_reg;
    logic [31:0]       word_next;
    logic              last_reg;
    logic [4:0]        p;
    logic [23:0]       norm;
    logic signed [8:0] expv;

    always_comb
    begin
        p = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (in_data.n[i])
            begin
                p = 5'(i);
            end
        end
        norm = in_data.n << (5'd23 - p);
        expv = 9'sd127 + $signed({4'd0, p}) - 9'(in_data.fl);

        if (in_data.mini)
        begin
            word_next = in_data.mini_word;
        end
        else if (in_data.nan)
        begin
            word_next = in_data.x;
        end
        else if (in_data.n == 24'd0)
        begin
            // stochastic rounding drops the sign of a zero result
            word_next = in_data.stoch ? 32'd0 : {in_data.sign, 31'd0};
        end
        else
        begin
            word_next = {in_data.sign, expv[7:0], norm[22:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            word_reg <= word_next;
            last_reg <= in_data.last;
        end
    end

    assign out_valid = valid_reg;
    assign word      = word_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/float_precision_trimmer.sv
// Pipeline: an accepted item passes through the decode, shift, round and pack registers
// before its result is valid at the output.
// Throughput: one item per cycle while out_ready holds; each stage advances with the next.
// A stalled output holds only the full stages; items behind a bubble keep moving.
// Reset (rst_n low, asynchronous) empties all stages and loads the
// configuration defaults: fixed mode, round to nearest, 8-bit formats, 10m/5e minifloat.
`include "float_precision_trimmer_macros.svh"

module float_precision_trimmer
    import fpt_pkg::*;
#(
    parameter int RANDOM_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [6:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            value_bits,
    input  logic [RANDOM_BITS-1:0] random_fraction,
    input  logic                   use_output_format,
    input  logic                   last_in_block,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            trimmed_bits,
    output logic                   last_out
);

    localparam int U_SHIFT = U_W - RANDOM_BITS;

    cfg_t cfg_reg;
    in_t  in_data;
    s1_t  s1_data;
    s2_t  s2_data;
    s3_t  s3_data;
    logic v1;
    logic v2;
    logic v3;
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= 1'b0;
            cfg_reg.stoch  <= 1'b0;
            cfg_reg.in_bw  <= 5'd8;
            cfg_reg.in_fl  <= 7'sd0;
            cfg_reg.out_bw <= 5'd8;
            cfg_reg.out_fl <= 7'sd0;
            cfg_reg.mbits  <= 5'd10;
            cfg_reg.ebits  <= 4'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:      cfg_reg.mode   <= cfg_data[0];
                REG_ROUNDING:  cfg_reg.stoch  <= cfg_data[0];
                REG_IN_BW:     cfg_reg.in_bw  <= cfg_data[4:0];
                REG_IN_FL:     cfg_reg.in_fl  <= $signed(cfg_data);
                REG_OUT_BW:    cfg_reg.out_bw <= cfg_data[4:0];
                REG_OUT_FL:    cfg_reg.out_fl <= $signed(cfg_data);
                REG_MANT_BITS: cfg_reg.mbits  <= cfg_data[4:0];
                REG_EXP_BITS:  cfg_reg.ebits  <= cfg_data[3:0];
                default:       cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // a stage advances when it is empty or the one after it advances
    assign en4      = !out_valid || out_ready;
    assign en3      = !v3 || en4;
    assign en2      = !v2 || en3;
    assign en1      = !v1 || en2;
    assign in_ready = en1;

    assign in_data.value   = value_bits;
    assign in_data.u39     = U_W'(random_fraction) << U_SHIFT;
    assign in_data.use_out = use_output_format;
    assign in_data.last    = last_in_block;

    fpt_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en1),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (v1),
        .out_data  (s1_data)
    );

    fpt_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .in_valid  (v1),
        .in_data   (s1_data),
        .out_valid (v2),
        .out_data  (s2_data)
    );

    fpt_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en3),
        .in_valid  (v2),
        .in_data   (s2_data),
        .out_valid (v3),
        .out_data  (s3_data)
    );

    fpt_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en4),
        .in_valid  (v3),
        .in_data   (s3_data),
        .out_valid (out_valid),
        .word      (trimmed_bits),
        .last      (last_out)
    );

    `FPT_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready)
    `FPT_ASSERT_NOW(a_ready_when_taken, out_ready, in_ready)
    `FPT_ASSERT_NOW(a_stall_only_when_full, !in_ready, v1 && v2 && v3 && out_valid)
    `FPT_ASSERT_NEXT(a_stall_holds_fill, !in_ready && !out_ready, v1 && v2 && v3 && out_valid)

endmodule
